// ----- design/rfs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfs_pkg: shared types and constants of the forest scorer
// Status codes, input command codes, forest limits and the node-word layout.
// ----------------------------------------------------------------------------
package rfs_pkg;

    // forest limits
    localparam int MAX_TREES    = 64;
    localparam int MAX_NODES    = 1024;
    localparam int MAX_FEATURES = 64;
    localparam int MAX_DEPTH    = 32;

    localparam int STATUS_W  = 2;
    localparam int PROB_W    = 17;
    localparam int VOTE_W    = 24;
    localparam int FVAL_W    = 32;
    localparam int CHILD_W   = 10;
    localparam int FEAT_W    = 6;
    localparam int CFG_W     = 7;
    localparam int IN_DATA_W = 160;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_FEAT  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DEPTH_ERR = 2'd2;

    localparam logic CMD_NODE    = 1'b0;
    localparam logic CMD_FEATURE = 1'b1;

    localparam logic CFG_TREE_COUNT    = 1'b0;
    localparam logic CFG_FEATURE_COUNT = 1'b1;

    // One stored node: leaf, left, right, feature, threshold, votes
    localparam int NODE_W = 1 + 2 * CHILD_W + FEAT_W + FVAL_W + 2 * VOTE_W;

    typedef struct packed {
        logic                     is_leaf;
        logic [CHILD_W-1:0]       left_child;
        logic [CHILD_W-1:0]       right_child;
        logic [FEAT_W-1:0]        split_feature;
        logic signed [FVAL_W-1:0] split_threshold;
        logic [VOTE_W-1:0]        vote_first;
        logic [VOTE_W-1:0]        vote_second;
    } node_t;

endpackage : rfs_pkg
`default_nettype wire

// ----- design/random_forest_scorer_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// A rejected node shows its result in the cycle right after acceptance.
// Scoring: a split node takes a node read, a feature read and a compare; a leaf
//   takes a node read and a divide, skipped for a zero-vote leaf; the final mean
//   is one more divide. Depth overrun ends the walk at once.
// Throughput: input is held off from the last feature until the result is taken.
// Reset: asynchronous active low; resets control, cursor and config registers.
// ----------------------------------------------------------------------------
// random_forest_scorer_core: stored-forest classifier
// Loads tree nodes and features, walks every tree and emits the mean leaf score.
// ----------------------------------------------------------------------------
module random_forest_scorer_core
    import rfs_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // tdata: tree_index, node_index, is_leaf, left_child, right_child,
    //        split_feature, split_threshold, vote_first, vote_second,
    //        feature_value
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [IN_DATA_W-1:0] s_tdata,
    // tuser: cmd
    input  wire logic                 s_tuser,
    // tlast: last_feature
    input  wire logic                 s_tlast,
    // tdata: probability
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [23:0]          m_tdata,
    // tuser: status
    output logic      [STATUS_W-1:0]  m_tuser,
    input  wire logic                 cfg_we,
    input  wire logic                 cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    localparam int TREE_W = (MAX_TREES > 1) ? $clog2(MAX_TREES) : 1;
    localparam int NIDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int FIDX_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int SLOT_W = TREE_W + NIDX_W;
    localparam int SLOTS  = MAX_TREES * MAX_NODES;
    localparam int DEP_W  = $clog2(MAX_DEPTH + 1);
    localparam int TCNT_W = $clog2(MAX_TREES + 1);
    localparam int SUM_W  = PROB_W + TCNT_W;
    localparam int DIV_W  = (SUM_W > VOTE_W + 16) ? SUM_W : VOTE_W + 16;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_NODE  = 8'b0000_0010,
        ST_FEAT  = 8'b0000_0100,
        ST_CMP   = 8'b0000_1000,
        ST_LDIV  = 8'b0001_0000,
        ST_LWAIT = 8'b0010_0000,
        ST_MDIV  = 8'b0100_0000,
        ST_MWAIT = 8'b1000_0000
    } state_t;

    // input field unpacking
    logic                     in_cmd;
    logic [5:0]               in_tree;
    logic [9:0]               in_node;
    node_t                    in_nd;
    logic [FVAL_W-1:0]        in_fval;
    logic                     in_last;
    assign in_cmd  = s_tuser;
    assign in_tree = s_tdata[5:0];
    assign in_node = s_tdata[15:6];
    assign in_nd.is_leaf         = s_tdata[16];
    assign in_nd.left_child      = s_tdata[26:17];
    assign in_nd.right_child     = s_tdata[36:27];
    assign in_nd.split_feature   = s_tdata[42:37];
    assign in_nd.split_threshold = s_tdata[74:43];
    assign in_nd.vote_first      = s_tdata[98:75];
    assign in_nd.vote_second     = s_tdata[122:99];
    assign in_fval = s_tdata[154:123];
    assign in_last = s_tlast;

    state_t               state_reg, state_next;
    logic [CFG_W-1:0]     tree_cnt_reg, feat_cnt_reg;
    logic [FIDX_W-1:0]    cursor_reg, cursor_next;
    logic [TCNT_W-1:0]    tree_reg, tree_next;
    logic [TCNT_W-1:0]    ntrees_reg, ntrees_next;
    logic [NIDX_W-1:0]    node_reg, node_next;
    logic [DEP_W-1:0]     depth_reg, depth_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic                 ovalid_reg, ovalid_next;
    logic [PROB_W-1:0]    oprob_reg, oprob_next;
    logic [STATUS_W-1:0]  ostat_reg, ostat_next;
    node_t                cur_reg, cur_next;

    logic                 accept;
    assign s_tready = (state_reg == ST_IDLE) && !ovalid_reg;
    assign accept   = s_tvalid && s_tready;

    // node memory
    logic                 node_we;
    logic [SLOT_W-1:0]    node_waddr, node_raddr;
    node_t                node_rd;
    logic [NODE_W-1:0]    node_rbits;
    rfs_ram #(.WIDTH(NODE_W), .DEPTH(SLOTS)) u_node_ram (
        .clk(clk), .we(node_we), .waddr(node_waddr), .wdata(in_nd),
        .raddr(node_raddr), .rdata(node_rbits)
    );
    assign node_rd = node_rbits;

    // feature memory
    logic                 feat_we;
    logic [FVAL_W-1:0]    feat_rd;
    rfs_ram #(.WIDTH(FVAL_W), .DEPTH(MAX_FEATURES)) u_feat_ram (
        .clk(clk), .we(feat_we), .waddr(cursor_reg), .wdata(in_fval),
        .raddr(node_rd.split_feature[FIDX_W-1:0]), .rdata(feat_rd)
    );

    // shared divider: leaf ratio and final mean
    logic                 div_start, div_done;
    logic [DIV_W-1:0]     div_num, div_quot;
    logic [VOTE_W:0]      div_den;
    rfs_divider #(.NUM_W(DIV_W), .DEN_W(VOTE_W + 1)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .numer(div_num),
        .denom(div_den), .done(div_done), .quot(div_quot)
    );

    logic                 node_ok;
    logic [VOTE_W:0]      vote_total;
    assign node_ok = (32'(in_tree) < 32'(MAX_TREES)) && (32'(in_node) < 32'(MAX_NODES));
    assign vote_total = {1'b0, cur_reg.vote_first} + {1'b0, cur_reg.vote_second};
    assign node_we = accept && (in_cmd == CMD_NODE) && node_ok
                     && (in_nd.is_leaf || ({1'b0, in_nd.split_feature} < feat_cnt_reg));
    assign node_waddr = {in_tree[TREE_W-1:0], in_node[NIDX_W-1:0]};
    // read address follows the next walk position so data is ready in ST_NODE
    assign node_raddr = {tree_next[TREE_W-1:0], node_next};
    assign feat_we = accept && (in_cmd == CMD_FEATURE);

    // control
    always_comb
    begin
        state_next  = state_reg;
        cursor_next = cursor_reg;
        tree_next   = tree_reg;
        ntrees_next = ntrees_reg;
        node_next   = node_reg;
        depth_next  = depth_reg;
        sum_next    = sum_reg;
        cur_next    = cur_reg;
        ovalid_next = ovalid_reg && !m_tready;
        oprob_next  = oprob_reg;
        ostat_next  = ostat_reg;
        div_start   = 1'b0;
        div_num     = '0;
        div_den     = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_cmd == CMD_NODE)
                begin
                    if (!in_nd.is_leaf && ({1'b0, in_nd.split_feature} >= feat_cnt_reg))
                    begin
                        ovalid_next = 1'b1;
                        oprob_next  = '0;
                        ostat_next  = STATUS_BAD_FEAT;
                    end
                end
                else if (accept)
                begin
                    cursor_next = cursor_reg + 1'b1;
                    if (32'(cursor_reg) == MAX_FEATURES - 1)
                    begin
                        cursor_next = '0;
                    end
                    if (in_last)
                    begin
                        cursor_next = '0;
                        tree_next   = '0;
                        node_next   = '0;
                        depth_next  = '0;
                        sum_next    = '0;
                        if (tree_cnt_reg == '0)
                        begin
                            ntrees_next = TCNT_W'(1);
                        end
                        else if (32'(tree_cnt_reg) > MAX_TREES)
                        begin
                            ntrees_next = TCNT_W'(MAX_TREES);
                        end
                        else
                        begin
                            ntrees_next = TCNT_W'(tree_cnt_reg);
                        end
                        state_next = ST_NODE;
                    end
                end
            end
            ST_NODE:
            begin
                // node read data valid now; feature read issued
                cur_next = node_rd;
                if (node_rd.is_leaf)
                begin
                    state_next = ST_LDIV;
                end
                else if (32'(depth_reg) >= MAX_DEPTH)
                begin
                    ovalid_next = 1'b1;
                    oprob_next  = '0;
                    ostat_next  = STATUS_DEPTH_ERR;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    state_next = ST_FEAT;
                end
            end
            ST_FEAT:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                // signed compare, left when feature <= threshold
                depth_next = depth_reg + 1'b1;
                if ($signed(feat_rd) <= cur_reg.split_threshold)
                begin
                    node_next = cur_reg.left_child[NIDX_W-1:0];
                end
                else
                begin
                    node_next = cur_reg.right_child[NIDX_W-1:0];
                end
                state_next = ST_NODE;
            end
            ST_LDIV:
            begin
                if (vote_total == '0)
                begin
                    state_next = ST_LWAIT;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_num    = DIV_W'({cur_reg.vote_first, 16'h0000});
                    div_den    = vote_total;
                    state_next = ST_LWAIT;
                end
            end
            ST_LWAIT:
            begin
                if (vote_total == '0 || div_done)
                begin
                    if (vote_total != '0)
                    begin
                        sum_next = sum_reg + SUM_W'(div_quot[PROB_W-1:0]);
                    end
                    node_next  = '0;
                    depth_next = '0;
                    if (tree_reg + 1'b1 == ntrees_reg)
                    begin
                        state_next = ST_MDIV;
                    end
                    else
                    begin
                        tree_next  = tree_reg + 1'b1;
                        state_next = ST_NODE;
                    end
                end
            end
            ST_MDIV:
            begin
                div_start  = 1'b1;
                div_num    = DIV_W'(sum_reg);
                div_den    = (VOTE_W + 1)'(ntrees_reg);
                state_next = ST_MWAIT;
            end
            ST_MWAIT:
            begin
                if (div_done)
                begin
                    ovalid_next = 1'b1;
                    oprob_next  = div_quot[PROB_W-1:0];
                    ostat_next  = STATUS_OK;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cursor_reg   <= '0;
            ovalid_reg   <= 1'b0;
            tree_cnt_reg <= CFG_W'(1);
            feat_cnt_reg <= CFG_W'(64);
            tree_reg     <= '0;
            ntrees_reg   <= '0;
            node_reg     <= '0;
            depth_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cursor_reg <= cursor_next;
            ovalid_reg <= ovalid_next;
            tree_reg   <= tree_next;
            ntrees_reg <= ntrees_next;
            node_reg   <= node_next;
            depth_reg  <= depth_next;
            if (cfg_we && cfg_index == CFG_TREE_COUNT)
            begin
                tree_cnt_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == CFG_FEATURE_COUNT)
            begin
                feat_cnt_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg   <= sum_next;
        cur_reg   <= cur_next;
        oprob_reg <= oprob_next;
        ostat_reg <= ostat_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {7'b0, oprob_reg};
    assign m_tuser  = ostat_reg;

endmodule : random_forest_scorer_core
`default_nettype wire

// ----- design/rfs_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfs_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule : rfs_ram
`default_nettype wire

// ----- design/rfs_divider.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfs_divider: radix-2 restoring divider
// Unsigned quotient of numer / denom, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rfs_divider #(
    parameter int NUM_W = 40,
    parameter int DEN_W = 25
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] numer,
    input  wire logic [DEN_W-1:0] denom,
    output logic                  done,
    output logic      [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quot_reg, quot_next;
    logic [DEN_W:0]   rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;

    assign trial = {rem_reg[DEN_W-1:0], quot_reg[NUM_W-1]};

    // one shift-subtract step per cycle
    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quot_next = numer;
            rem_next  = '0;
            den_next  = denom;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next  = trial - {1'b0, den_reg};
                quot_next = {quot_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial;
                quot_next = {quot_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule : rfs_divider
`default_nettype wire

// ----- design/rfs_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfs_checker: port-level assertions for the forest scorer
// Checks output status codes, probability range and transaction ordering.
// ----------------------------------------------------------------------------
module rfs_checker (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [23:0]  m_tdata,
    input wire logic [1:0]   m_tuser
);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // status never takes the unused code
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser != 2'd3)
        else $error("bad status code");

    // error results carry zero probability
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != 2'd0 |-> m_tdata[16:0] == 17'd0)
        else $error("error result with nonzero probability");

    // probability never above one
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[16:0] <= 17'd65536)
        else $error("probability out of range");

    // no new input taken while a result is pending
    a_noaccept: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("input taken with pending result");

endmodule : rfs_checker

bind random_forest_scorer_core rfs_checker u_rfs_checker (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);
`default_nettype wire

// ----- tb/random_forest_scorer_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// random_forest_scorer_core_test: self-checking bench for the forest scorer
// Loads tree nodes and feature vectors over the input stream, predicts every
// score and rejection in a scoreboard and compares results field by field.
// ----------------------------------------------------------------------------
module random_forest_scorer_core_test;
    import rfs_pkg::*;

    localparam int NTREES   = 64;
    localparam int NNODES   = 1024;
    localparam int NFEAT    = 64;
    localparam int DEPTH    = 32;
    localparam int WD_LIMIT = 200000;
    localparam logic signed [31:0] FV_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] FV_MAX = 32'sh7FFF_FFFF;
    localparam logic [23:0] VOTE_MAX = 24'hFF_FFFF;

    typedef struct {
        logic                     cmd;
        logic [5:0]               tree;
        logic [9:0]               node;
        logic                     leaf;
        logic [9:0]               left;
        logic [9:0]               right;
        logic [5:0]               feat;
        logic signed [31:0]       thr;
        logic [23:0]              vf;
        logic [23:0]              vs;
        logic signed [31:0]       fv;
        logic                     last;
    } stim_t;

    typedef struct {
        logic [PROB_W-1:0]   prob;
        logic [STATUS_W-1:0] status;
    } score_t;

    // Scoreboard: holds its own forest copy and the queue of expected scores
    class forest_scoreboard;
        node_t              nodes[int];
        logic signed [31:0] feats[NFEAT];
        logic [5:0]         cursor;
        int                 tree_cnt;
        int                 feat_cnt;
        score_t             expected_scores[$];
        int                 errors;

        function new();
            cursor   = 0;
            tree_cnt = 1;
            feat_cnt = 64;
            errors   = 0;
        endfunction

        function void note_cfg(logic idx, int val);
            if (idx == CFG_TREE_COUNT)
                tree_cnt = val;
            else
                feat_cnt = val;
        endfunction

        // walk one tree; returns 0 on depth overrun
        function bit walk_tree(int t, output longint unsigned leaf_val);
            int                 node;
            int                 splits;
            node_t              n;
            longint unsigned    total;
            node     = 0;
            splits   = 0;
            leaf_val = 0;
            forever
            begin
                n = nodes[t * NNODES + node];
                if (n.is_leaf)
                begin
                    total = longint'(n.vote_first) + longint'(n.vote_second);
                    leaf_val = (total == 0) ? 0 : ((longint'(n.vote_first) << 16) / total);
                    return 1;
                end
                if (splits >= DEPTH)
                    return 0;
                splits++;
                if (feats[n.split_feature] <= n.split_threshold)
                    node = n.left_child;
                else
                    node = n.right_child;
            end
        endfunction

        function void note_input(stim_t it);
            node_t           n;
            score_t          s;
            int              cnt;
            longint unsigned sum;
            longint unsigned v;
            if (it.cmd == CMD_NODE)
            begin
                if (!it.leaf && int'(it.feat) >= feat_cnt)
                begin
                    s.prob   = '0;
                    s.status = STATUS_BAD_FEAT;
                    expected_scores.push_back(s);
                    return;
                end
                n.is_leaf         = it.leaf;
                n.left_child      = it.left;
                n.right_child     = it.right;
                n.split_feature   = it.feat;
                n.split_threshold = it.thr;
                n.vote_first      = it.vf;
                n.vote_second     = it.vs;
                nodes[int'(it.tree) * NNODES + int'(it.node)] = n;
                return;
            end
            feats[cursor] = it.fv;
            cursor        = cursor + 6'd1;
            if (!it.last)
                return;
            cursor = 0;
            cnt = (tree_cnt < 1) ? 1 : (tree_cnt > NTREES) ? NTREES : tree_cnt;
            sum = 0;
            for (int t = 0; t < cnt; t++)
            begin
                if (!walk_tree(t, v))
                begin
                    s.prob   = '0;
                    s.status = STATUS_DEPTH_ERR;
                    expected_scores.push_back(s);
                    return;
                end
                sum += v;
            end
            s.prob   = PROB_W'(sum / cnt);
            s.status = STATUS_OK;
            expected_scores.push_back(s);
        endfunction

        function void check(logic [23:0] d, logic [STATUS_W-1:0] st);
            score_t s;
            if (expected_scores.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: prob %0d status %0d", d[16:0], st);
                return;
            end
            s = expected_scores.pop_front();
            if (d[16:0] !== s.prob || st !== s.status)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected prob %0d status %0d, got prob %0d status %0d",
                             s.prob, s.status, d[16:0], st);
            end
        endfunction

        function int pending();
            return expected_scores.size();
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [IN_DATA_W-1:0] s_tdata = '0;
    logic                 s_tuser = 1'b0;
    logic                 s_tlast = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [23:0]          m_tdata;
    logic [STATUS_W-1:0]  m_tuser;
    logic                 cfg_we = 1'b0;
    logic                 cfg_index = 1'b0;
    logic [CFG_W-1:0]     cfg_data = '0;

    stim_t              bus_item;
    forest_scoreboard   sb;
    int                 idle_pct = 0;
    int                 stall_pct = 0;
    int                 idle_cnt = 0;
    int                 tc_now = 1;
    int                 fc_now = 64;
    bit                 wr_map[NTREES][NNODES];
    int                 wr_list[NTREES][$];
    logic signed [31:0] fv_shadow[NFEAT];
    logic [5:0]         fv_cursor = 0;

    random_forest_scorer_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // receiver backpressure
    always @(posedge clk)
    begin
        if (stall_pct == 0)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // transaction monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_input(bus_item);
            if (m_tvalid && m_tready)
                sb.check(m_tdata, m_tuser);
        end
    end

    // watchdog on cycles with no transaction
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WD_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // tdata: tree_index, node_index, is_leaf, left_child, right_child,
    //        split_feature, split_threshold, vote_first, vote_second,
    //        feature_value
    function automatic logic [IN_DATA_W-1:0] pack_item(stim_t it);
        logic [IN_DATA_W-1:0] d;
        d          = '0;
        d[5:0]     = it.tree;
        d[15:6]    = it.node;
        d[16]      = it.leaf;
        d[26:17]   = it.left;
        d[36:27]   = it.right;
        d[42:37]   = it.feat;
        d[74:43]   = it.thr;
        d[98:75]   = it.vf;
        d[122:99]  = it.vs;
        d[154:123] = it.fv;
        return d;
    endfunction

    function automatic stim_t noise_item();
        stim_t it;
        it.cmd   = 1'($urandom_range(1));
        it.tree  = 6'($urandom);
        it.node  = 10'($urandom);
        it.leaf  = 1'($urandom_range(1));
        it.left  = 10'($urandom);
        it.right = 10'($urandom);
        it.feat  = 6'($urandom);
        it.thr   = $urandom;
        it.vf    = 24'($urandom);
        it.vs    = 24'($urandom);
        it.fv    = $urandom;
        it.last  = 1'($urandom_range(1));
        return it;
    endfunction

    task automatic send(stim_t it);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pack_item(it);
        s_tuser  <= it.cmd;
        s_tlast  <= it.last;
        bus_item <= it;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // node write; keeps track of which slots are stored
    task automatic send_node(int t, int idx, bit leaf, int l, int r, int f,
                             logic signed [31:0] thr, logic [23:0] vf, logic [23:0] vs);
        stim_t it;
        it      = noise_item();
        it.cmd  = CMD_NODE;
        it.tree = 6'(t);
        it.node = 10'(idx);
        it.leaf = leaf;
        it.left = 10'(l);
        it.right = 10'(r);
        it.feat = 6'(f);
        it.thr  = thr;
        it.vf   = vf;
        it.vs   = vs;
        send(it);
        if ((leaf || f < fc_now) && !wr_map[t][idx])
        begin
            wr_map[t][idx] = 1'b1;
            wr_list[t].push_back(idx);
        end
    endtask

    task automatic send_feat(logic signed [31:0] v, bit last);
        stim_t it;
        it      = noise_item();
        it.cmd  = CMD_FEATURE;
        it.fv   = v;
        it.last = last;
        send(it);
        fv_shadow[fv_cursor] = v;
        fv_cursor = last ? 6'd0 : fv_cursor + 6'd1;
    endtask

    // wait until the block is idle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_cfg(logic idx, int val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(val);
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.note_cfg(idx, val);
        if (idx == CFG_TREE_COUNT)
            tc_now = val;
        else
            fc_now = val;
        @(posedge clk);
    endtask

    function automatic int active_trees();
        return (tc_now < 1) ? 1 : (tc_now > NTREES) ? NTREES : tc_now;
    endfunction

    function automatic int pick_child(int t, int self_idx);
        int k;
        k = $urandom_range(wr_list[t].size());
        return (k == wr_list[t].size()) ? self_idx : wr_list[t][k];
    endfunction

    function automatic logic [23:0] rand_vote();
        case ($urandom_range(3))
            0: return 24'd0;
            1: return VOTE_MAX;
            2: return 24'($urandom_range(15));
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic signed [31:0] rand_fval();
        case ($urandom_range(5))
            0: return FV_MIN;
            1: return FV_MAX;
            2: return 32'($urandom_range(7)) - 32'd4;
            default: return $urandom;
        endcase
    endfunction

    // one random transaction: mostly well-formed node edits and vectors
    task automatic random_item();
        int t;
        int idx;
        int f;
        bit leaf;
        logic signed [31:0] thr;
        if ($urandom_range(99) < 50)
        begin
            t = ($urandom_range(99) < 80) ? $urandom_range(active_trees() - 1)
                                          : $urandom_range(NTREES - 1);
            if (wr_list[t].size() != 0 && $urandom_range(99) < 60)
                idx = wr_list[t][$urandom_range(wr_list[t].size() - 1)];
            else
                idx = $urandom_range(NNODES - 1);
            leaf = ($urandom_range(99) < 40);
            f    = $urandom_range(NFEAT - 1);
            thr  = ($urandom_range(2) == 0) ? fv_shadow[f] : rand_fval();
            send_node(t, idx, leaf, pick_child(t, idx), pick_child(t, idx), f, thr,
                      rand_vote(), rand_vote());
        end
        else
            send_feat(rand_fval(), $urandom_range(5) == 0);
    endtask

    // give every walked tree a stored root
    task automatic seed_roots();
        for (int t = 0; t < active_trees(); t++)
            if (!wr_map[t][0])
                send_node(t, 0, 1'b1, 0, 0, 0, 0, rand_vote(), rand_vote());
    endtask

    task automatic run_phase(int tc, int fc, int n, int ip, int sp);
        drain();
        write_cfg(CFG_TREE_COUNT, tc);
        write_cfg(CFG_FEATURE_COUNT, fc);
        idle_pct  = ip;
        stall_pct = sp;
        seed_roots();
        repeat (n) random_item();
    endtask

    initial
    begin
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: defaults, zero-total leaf, full vector with extreme values
        write_cfg(CFG_TREE_COUNT, 1);
        write_cfg(CFG_FEATURE_COUNT, 64);
        send_node(0, 0, 1'b1, 0, 0, 0, 0, 24'd0, 24'd0);
        for (int i = 0; i < NFEAT; i++)
            send_feat((i == 0) ? FV_MIN : (i == 1) ? FV_MAX : (i == 2) ? 0 :
                      (i == 3) ? -1 : rand_fval(), i == NFEAT - 1);
        // split at the extremes of the threshold, equality goes left
        send_node(0, 1, 1'b1, 0, 0, 0, 0, VOTE_MAX, 24'd0);
        send_node(0, 2, 1'b1, 0, 0, 0, 0, 24'd0, VOTE_MAX);
        send_node(0, 3, 1'b1, 0, 0, 0, 0, VOTE_MAX, VOTE_MAX);
        send_node(0, 0, 1'b0, 1, 2, 0, FV_MAX, 0, 0);
        send_feat(FV_MIN, 1'b1);
        send_node(0, 0, 1'b0, 1, 2, 0, FV_MIN, 0, 0);
        send_feat(FV_MIN, 1'b1);
        send_feat(FV_MAX, 1'b1);
        send_node(0, 0, 1'b0, 3, 3, 63, 0, 0, 0);
        send_feat(7, 1'b1);
        // self loop runs into the depth limit
        send_node(0, 0, 1'b0, 0, 0, 5, 0, 0, 0);
        send_feat(3, 1'b1);
        send_node(63, 1023, 1'b1, 1023, 1023, 63, FV_MAX, VOTE_MAX, 24'd1);
        send_node(0, 0, 1'b1, 0, 0, 0, 0, 24'd3, 24'd1);

        // rejected node and a leaf that is never rejected
        drain();
        write_cfg(CFG_FEATURE_COUNT, 1);
        send_node(1, 4, 1'b0, 4, 4, 1, 0, 0, 0);
        send_node(1, 4, 1'b1, 4, 4, 63, 0, 24'd1, 24'd2);
        send_node(1, 0, 1'b0, 4, 4, 0, 0, 0, 0);

        // chain of exactly the depth limit, then one split more
        drain();
        write_cfg(CFG_TREE_COUNT, 3);
        write_cfg(CFG_FEATURE_COUNT, 64);
        send_node(2, DEPTH, 1'b1, 0, 0, 0, 0, 24'd1, 24'd1);
        for (int k = DEPTH - 1; k >= 0; k--)
            send_node(2, k, 1'b0, k + 1, k + 1, k, 0, 0, 0);
        send_feat(1, 1'b1);
        send_node(2, DEPTH + 1, 1'b1, 0, 0, 0, 0, 24'd1, 24'd0);
        send_node(2, DEPTH, 1'b0, DEPTH + 1, DEPTH + 1, 9, 0, 0, 0);
        send_feat(2, 1'b1);

        // random phases across settings, idling and backpressure
        run_phase(1, 64, 80, 0, 0);
        run_phase($urandom_range(2, 8), 1, 220, 55, 0);
        run_phase(0, 127, 220, 0, 55);
        run_phase(127, 64, 50, 29, 29);
        run_phase(64, 0, 60, 0, 0);
        run_phase($urandom_range(1, 8), $urandom_range(1, 64), 240, 55, 0);
        run_phase($urandom_range(1, 8), $urandom_range(1, 64), 240, 0, 55);
        run_phase($urandom_range(1, 8), $urandom_range(1, 64), 240, 29, 29);
        run_phase($urandom_range(1, 4), 64, 220, 0, 0);

        drain();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
